// ===== rtl/tgad_pkg.sv =====
// ----------------------------------------------------------------------------
// tgad_pkg
// Shared types and constants for the uncompressed TGA stream decoder.
// ----------------------------------------------------------------------------
package tgad_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes.
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_SIGNATURE = 2'd1;
  localparam logic [1:0] ERR_FORMAT    = 2'd2;
  localparam logic [1:0] ERR_TRUNCATED = 2'd3;

  // Header byte positions.
  localparam logic [4:0] POS_SIG_TYPE  = 5'd2;
  localparam logic [4:0] POS_SIG_LAST  = 5'd3;
  localparam logic [4:0] POS_WIDTH_LO  = 5'd12;
  localparam logic [4:0] POS_WIDTH_HI  = 5'd13;
  localparam logic [4:0] POS_HEIGHT_LO = 5'd14;
  localparam logic [4:0] POS_HEIGHT_HI = 5'd15;
  localparam logic [4:0] POS_DEPTH     = 5'd16;
  localparam logic [4:0] POS_DESC      = 5'd17;

  // Header values.
  localparam logic [7:0] SIG_TYPE_BYTE = 8'h02;
  localparam logic [7:0] SIG_ZERO_BYTE = 8'h00;
  localparam logic [4:0] BPP_RGB       = 5'd3;
  localparam logic [4:0] BPP_RGBA      = 5'd4;
  localparam logic [7:0] ALPHA_OPAQUE  = 8'hFF;

  // One decoded result.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        has_alpha;
    logic [1:0]  error_code;
    logic        last_pixel;
  } tgad_result_t;

endpackage

// ===== rtl/tgad_decode.sv =====
// ----------------------------------------------------------------------------
// tgad_decode
// Header parser and pixel assembler: file state and per-byte result logic.
// ----------------------------------------------------------------------------
module tgad_decode (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  end_of_file_i,
  output logic                  res_valid_o,
  output tgad_pkg::tgad_result_t res_o
);
  import tgad_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PIXELS,
    PH_DONE
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [4:0]  pos_q, pos_d;
  logic        sig_bad_q, sig_bad_d;
  logic        depth_ok_q, depth_ok_d;
  logic        four_q, four_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [1:0]  bip_q, bip_d;
  logic [31:0] remain_q, remain_d;
  logic [7:0]  pb_q [3];
  logic [7:0]  pb_d [3];

  logic [7:0]  sig_expect;
  logic [4:0]  bpp;
  logic [31:0] pixel_count;
  logic        pixel_done;
  logic        is_last;

  assign sig_expect  = (pos_q == POS_SIG_TYPE) ? SIG_TYPE_BYTE : SIG_ZERO_BYTE;
  assign bpp         = data_byte_i[7:3];
  assign pixel_count = width_q * height_q;
  assign pixel_done  = four_q ? (bip_q == 2'd3) : (bip_q >= 2'd2);
  assign is_last     = (remain_q == 32'd1);

  // Next-state and result for the byte in the stage register.
  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    sig_bad_d   = sig_bad_q;
    depth_ok_d  = depth_ok_q;
    four_d      = four_q;
    width_d     = width_q;
    height_d    = height_q;
    bip_d       = bip_q;
    remain_d    = remain_q;
    pb_d        = pb_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    unique case (phase_q)
      PH_HEADER: begin
        // Capture the header fields at their positions.
        if (pos_q <= POS_SIG_LAST) begin
          if (data_byte_i != sig_expect) sig_bad_d = 1'b1;
        end
        if (pos_q == POS_WIDTH_LO)  width_d[7:0]   = data_byte_i;
        if (pos_q == POS_WIDTH_HI)  width_d[15:8]  = data_byte_i;
        if (pos_q == POS_HEIGHT_LO) height_d[7:0]  = data_byte_i;
        if (pos_q == POS_HEIGHT_HI) height_d[15:8] = data_byte_i;
        if (pos_q == POS_DEPTH) begin
          depth_ok_d = (bpp == BPP_RGB) || (bpp == BPP_RGBA);
          four_d     = (bpp == BPP_RGBA);
        end

        // Decide what this byte reports.
        priority if (pos_q == POS_SIG_LAST && sig_bad_d) begin
          res_valid_o      = 1'b1;
          res_o.kind       = KIND_ERROR;
          res_o.error_code = ERR_SIGNATURE;
          phase_d          = PH_DONE;
        end else if (pos_q == POS_DESC) begin
          res_valid_o = 1'b1;
          priority if (!depth_ok_q || width_q == 16'd0 || height_q == 16'd0) begin
            res_o.kind       = KIND_ERROR;
            res_o.error_code = ERR_FORMAT;
            phase_d          = PH_DONE;
          end else if (end_of_file_i) begin
            res_o.kind       = KIND_ERROR;
            res_o.error_code = ERR_TRUNCATED;
            phase_d          = PH_DONE;
          end else begin
            res_o.kind         = KIND_HEADER;
            res_o.image_width  = width_q;
            res_o.image_height = height_q;
            res_o.has_alpha    = four_q;
            remain_d           = pixel_count;
            bip_d              = 2'd0;
            phase_d            = PH_PIXELS;
          end
        end else if (end_of_file_i) begin
          res_valid_o      = 1'b1;
          res_o.kind       = KIND_ERROR;
          res_o.error_code = sig_bad_d ? ERR_SIGNATURE : ERR_TRUNCATED;
          phase_d          = PH_DONE;
        end else begin
          pos_d = pos_q + 5'd1;
        end
      end

      PH_PIXELS: begin
        res_valid_o = 1'b0;
        if (pixel_done) begin
          res_valid_o = 1'b1;
          if (end_of_file_i && !is_last) begin
            res_o.kind       = KIND_ERROR;
            res_o.error_code = ERR_TRUNCATED;
            phase_d          = PH_DONE;
          end else begin
            res_o.kind       = KIND_PIXEL;
            res_o.green      = pb_q[1];
            res_o.blue       = pb_q[0];
            res_o.red        = four_q ? pb_q[2] : data_byte_i;
            res_o.alpha      = four_q ? data_byte_i : ALPHA_OPAQUE;
            res_o.last_pixel = is_last;
            bip_d            = 2'd0;
            if (remain_q != 32'd0) remain_d = remain_q - 32'd1;
            if (is_last) phase_d = PH_DONE;
          end
        end else begin
          // Store a colour byte; only the first three are ever buffered.
          unique case (bip_q)
            2'd0:    pb_d[0] = data_byte_i;
            2'd1:    pb_d[1] = data_byte_i;
            default: pb_d[2] = data_byte_i;
          endcase
          bip_d = bip_q + 2'd1;
          if (end_of_file_i) begin
            res_valid_o      = 1'b1;
            res_o.kind       = KIND_ERROR;
            res_o.error_code = ERR_TRUNCATED;
            phase_d          = PH_DONE;
          end
        end
      end

      default: begin
        // Finished or failed: wait for the end of the file.
        res_valid_o = 1'b0;
      end
    endcase

    // The end of every file returns the parser to a fresh header.
    if (end_of_file_i) begin
      phase_d    = PH_HEADER;
      pos_d      = 5'd0;
      sig_bad_d  = 1'b0;
      depth_ok_d = 1'b0;
      four_d     = 1'b0;
      width_d    = 16'd0;
      height_d   = 16'd0;
      bip_d      = 2'd0;
      remain_d   = 32'd0;
    end
  end

  // File state; the colour buffer is payload and holds no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      pos_q      <= 5'd0;
      sig_bad_q  <= 1'b0;
      depth_ok_q <= 1'b0;
      four_q     <= 1'b0;
      width_q    <= 16'd0;
      height_q   <= 16'd0;
      bip_q      <= 2'd0;
      remain_q   <= 32'd0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      sig_bad_q  <= sig_bad_d;
      depth_ok_q <= depth_ok_d;
      four_q     <= four_d;
      width_q    <= width_d;
      height_q   <= height_d;
      bip_q      <= bip_d;
      remain_q   <= remain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      pb_q <= pb_d;
    end
  end

endmodule

// ===== rtl/tga_uncompressed_decoder_core.sv =====
// ----------------------------------------------------------------------------
// tga_uncompressed_decoder_core
// Streaming decoder for uncompressed true-colour TGA files.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one file byte per request, with end_of_file_i
// marking the final byte. A request is taken when in_valid_i is high and
// in_stall_o is low. The output channel presents one result per request
// that produces one: a header result, a pixel, or an error, on out_valid_o,
// taken when out_stall_i is low.
// Each byte is latched into an input register and decoded into the result
// register once that register is free. One byte is taken every cycle
// while the receiver does not stall; the decode between the input and
// result registers is combinational, including one 16 by 16 multiply
// for the pixel count.
// When the receiver stalls, the held result stays unchanged and a further
// byte is taken only into an empty input register; in_stall_o is then high.
// Reset clears both valid bits and returns the parser to the start of a file.
// Pixels already delivered before a truncation error are to be discarded.
// ----------------------------------------------------------------------------
module tga_uncompressed_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_file_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o,
  output logic [15:0] image_width_o,
  output logic [15:0] image_height_o,
  output logic        has_alpha_o,
  output logic [1:0]  error_code_o,
  output logic        last_pixel_o
);
  import tgad_pkg::*;

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         in_eof_q;
  logic         out_valid_q;
  tgad_result_t out_q;
  logic         out_free;
  logic         step;
  logic         accept;
  logic         res_valid;
  tgad_result_t res;

  // Handshake control.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  // Parser for the byte held in the input register.
  tgad_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .data_byte_i   (in_byte_q),
    .end_of_file_i (in_eof_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // Input register valid and result register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= step && res_valid;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= data_byte_i;
      in_eof_q  <= end_of_file_i;
    end
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  // Output fields.
  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_q.kind;
  assign red_o          = out_q.red;
  assign green_o        = out_q.green;
  assign blue_o         = out_q.blue;
  assign alpha_o        = out_q.alpha;
  assign image_width_o  = out_q.image_width;
  assign image_height_o = out_q.image_height;
  assign has_alpha_o    = out_q.has_alpha;
  assign error_code_o   = out_q.error_code;
  assign last_pixel_o   = out_q.last_pixel;

endmodule
